// ===== design/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg
// Types and constants shared by the indexed shift list core and its cells.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int GROUP   = 8;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_WRITE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_en;
  } cell_ctrl_t;

endpackage

// ===== design/isl_cell.sv =====
// ----------------------------------------------------------------------------
// isl_cell
// One slot of the list. It holds an entry and takes a new value from the
// write data or from a neighbor, and drives its entry onto the read tree.
// ----------------------------------------------------------------------------
module isl_cell #(
  parameter int IDX_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  isl_pkg::cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0]          idx,
  input  logic [isl_pkg::DATA_W-1:0] wr_data,
  input  logic [isl_pkg::DATA_W-1:0] left_data,
  input  logic [isl_pkg::DATA_W-1:0] right_data,
  output logic [isl_pkg::DATA_W-1:0] data,
  output logic [isl_pkg::DATA_W-1:0] rd_data
);
  import isl_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic              hit;
  logic              above;

  assign hit   = (idx == MY_IDX);
  assign above = (MY_IDX > idx);

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (hit) begin
          entry_nxt = wr_data;
        end else if (above) begin
          entry_nxt = left_data;
        end
      end
      CELL_REMOVE: begin
        if (hit || above) begin
          entry_nxt = right_data;
        end
      end
      CELL_WRITE: begin
        if (hit) begin
          entry_nxt = wr_data;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign data    = entry_r;
  assign rd_data = (ctrl.rd_en && hit) ? entry_r : '0;

endmodule

// ===== design/indexed_shift_list_core.sv =====
// ----------------------------------------------------------------------------
// indexed_shift_list_core
// Ordered list with insert, remove, read and write at an index, kept in a
// row of cells that shift their entries to a neighbor in parallel.
// ----------------------------------------------------------------------------
//   Channel  Direction  Word contents
//   in_      slave      tuser: mode, at_end; tdata: position, entry_data
//   out_     master     tuser: status; tdata: data_out, item_count, is_empty
//
// One word is accepted per cycle while in_tready is high.
// All cells update the list in the cycle the word is accepted; the read value
// then passes a registered OR tree over groups of eight cells.
// Reset clears the count and the handshake state; the entries are not cleared.
// A stalled output holds the result and the stage before it, and in_tready
// falls while both are occupied.
module indexed_shift_list_core #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // mode[1:0], at_end[2]
  input  logic [39:0] in_tdata,   // position[5:0], entry_data[37:6], zero[39:38]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic [39:0] out_tdata   // data_out[31:0], item_count[38:32], is_empty[39]
);
  import isl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int NG = (CAPACITY + GROUP - 1) / GROUP;

  mode_t             mode;
  logic              at_end;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] entry_data;

  logic              accept;
  logic              s1_adv;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [XW-1:0]     count_x;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     idx_x;
  status_t           status;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [DATA_W-1:0] rd_pad    [NG*GROUP];
  logic [DATA_W-1:0] part      [NG];
  logic [DATA_W-1:0] part_r    [NG];
  logic [DATA_W-1:0] rd_all;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  status_t           s1_status_r;
  logic [CW-1:0]     s1_count_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic [COUNT_W-1:0] out_count_r;
  logic              out_empty_r;

  assign mode       = mode_t'(in_tuser[1:0]);
  assign at_end     = in_tuser[2];
  assign position   = in_tdata[POS_W-1:0];
  assign entry_data = in_tdata[POS_W+DATA_W-1:POS_W];

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  assign count_x = XW'(count_r);
  assign pos_x   = XW'(position);

  always_comb begin
    status    = ST_OK;
    idx_x     = pos_x;
    count_nxt = count_r;
    ctrl.op   = CELL_HOLD;
    ctrl.rd_en = 1'b0;
    case (mode)
      MODE_INSERT: begin
        idx_x = at_end ? count_x : pos_x;
        if (count_r == CW'(CAPACITY)) begin
          status = ST_FULL;
        end else if (idx_x > count_x) begin
          status = ST_RANGE;
        end else begin
          ctrl.op   = CELL_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_REMOVE: begin
        idx_x = at_end ? (count_x - 1'b1) : pos_x;
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (idx_x >= count_x) begin
          status = ST_RANGE;
        end else begin
          ctrl.op    = CELL_REMOVE;
          ctrl.rd_en = 1'b1;
          count_nxt  = count_r - 1'b1;
        end
      end
      MODE_READ: begin
        if (pos_x >= count_x) begin
          status = ST_RANGE;
        end else begin
          ctrl.rd_en = 1'b1;
        end
      end
      default: begin
        if (pos_x >= count_x) begin
          status = ST_RANGE;
        end else begin
          ctrl.op = CELL_WRITE;
        end
      end
    endcase
    if (!accept) begin
      ctrl.op    = CELL_HOLD;
      ctrl.rd_en = 1'b0;
      count_nxt  = count_r;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = entry_data;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    isl_cell #(
      .IDX_W    (CW),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (idx_x[CW-1:0]),
      .wr_data    (entry_data),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  for (genvar i = 0; i < NG*GROUP; i++) begin : g_pad
    if (i < CAPACITY) begin : g_real
      assign rd_pad[i] = cell_rd[i];
    end else begin : g_zero
      assign rd_pad[i] = '0;
    end
  end

  for (genvar g = 0; g < NG; g++) begin : g_group
    always_comb begin
      part[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        part[g] = part[g] | rd_pad[g*GROUP + k];
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        part_r[g] <= part[g];
      end
    end
  end

  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NG; g++) begin
      rd_all = rd_all | part_r[g];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
      s1_count_r  <= count_nxt;
    end
    if (s1_valid_r && s1_adv) begin
      out_status_r <= s1_status_r;
      out_data_r   <= rd_all;
      out_count_r  <= COUNT_W'(s1_count_r);
      out_empty_r  <= (s1_count_r == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_empty_r, out_count_r, out_data_r};

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("List count exceeds capacity.");

  a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_data_r == '0))
    else $error("Failed operation returned nonzero data.");

  a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ctrl.op == CELL_INSERT)) |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("Insert did not advance the count.");

  a_remove_count : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ctrl.op == CELL_REMOVE)) |=> (count_r == CW'($past(count_r) - 1'b1)))
    else $error("Remove did not reduce the count.");
`endif

endmodule
